// ===== hw/rtl/nta_pkg.sv =====
package nta_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_NUM_IFACES  = 4;

  localparam int IFACE_W = 2;
  localparam int ID_W    = 32;
  localparam int AGE_W   = 10;
  localparam int COUNT_W = 5;
  localparam int HELLO_W = 8;

  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [HELLO_W-1:0] HELLO_RST = 8'd5;

  localparam logic KIND_HELLO = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [IFACE_W-1:0] iface_index;
    logic [ID_W-1:0]    nbr_router_id;
    logic [ID_W-1:0]    nbr_address;
    logic [ID_W-1:0]    nbr_netmask;
  } in_item_t;

  typedef struct packed {
    logic               lsu_needed;
    logic               added;
    logic               refreshed;
    logic               full_drop;
    logic [COUNT_W-1:0] expired_count;
    logic [COUNT_W-1:0] iface_nbr_count;
  } out_item_t;

  typedef struct packed {
    logic [IFACE_W-1:0] iface;
    logic [ID_W-1:0]    peer_id;
    logic [ID_W-1:0]    address;
    logic [ID_W-1:0]    netmask;
    logic [AGE_W-1:0]   age;
  } entry_t;

endpackage

// ===== hw/rtl/neighbor_table_with_aging_core.sv =====
// Channel  | Ports                          | Direction
// ---------+--------------------------------+-----------
// input    | in_valid, in_stall, in_item    | hello/tick in
// result   | out_valid, out_stall, out_item | one result per item
// config   | cfg_valid, cfg_ready, cfg_data | hello_interval write
//
// Each item walks the entry memory once, one read per cycle through its
// single read port; a new item is taken only in ST_IDLE, after the last result is registered.
// Reset (synchronous, rst_n low) clears valid bits, interface counts and
// control; entry contents are not cleared and no clearing pass is needed.
// A stalled result sits in the output register while the next item runs.
module neighbor_table_with_aging_core
  import nta_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int NUM_IFACES  = DEF_NUM_IFACES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [HELLO_W-1:0] cfg_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int PW   = AW + 1;
  localparam int IW   = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN, ST_OUT} state_t;

  state_t              state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                hit_fnd_r, hit_fnd_nxt;
  logic [AW-1:0]       hit_idx_r, hit_idx_nxt;
  logic                free_fnd_r, free_fnd_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic [COUNT_W-1:0]  exp_r, exp_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNTW-1:0]     cnt_r [NUM_IFACES];
  logic [CNTW-1:0]     cnt_nxt [NUM_IFACES];
  logic [HELLO_W-1:0]  hello_r, hello_nxt;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  entry_t              mem [TABLE_DEPTH];
  entry_t              rd_data_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;

  logic [AGE_W-1:0]    limit;
  logic                ifc_ok;
  logic [IW-1:0]       ifc_idx;
  logic [IW-1:0]       f_idx;
  logic                f_ok;
  logic [CNTW-1:0]     cnt_after;
  entry_t              new_entry;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign limit   = AGE_W'({2'b00, hello_r}) + AGE_W'({1'b0, hello_r, 1'b0});
  assign ifc_ok  = 32'(item_r.iface_index) < 32'(NUM_IFACES);
  assign ifc_idx = IW'(item_r.iface_index);
  assign f_ok    = 32'(rd_data_r.iface) < 32'(NUM_IFACES);
  assign f_idx   = IW'(rd_data_r.iface);

  always_comb begin
    new_entry.iface   = item_r.iface_index;
    new_entry.peer_id = item_r.nbr_router_id;
    new_entry.address = item_r.nbr_address;
    new_entry.netmask = item_r.nbr_netmask;
    new_entry.age     = '0;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    ptr_nxt       = ptr_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    hit_fnd_nxt   = hit_fnd_r;
    hit_idx_nxt   = hit_idx_r;
    free_fnd_nxt  = free_fnd_r;
    free_idx_nxt  = free_idx_r;
    exp_nxt       = exp_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    hello_nxt     = hello_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = chk_idx_r;
    wr_data       = rd_data_r;
    cnt_after     = cnt_r[ifc_idx];

    if (cfg_valid) begin
      hello_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_item;
          ptr_nxt      = '0;
          hit_fnd_nxt  = 1'b0;
          free_fnd_nxt = 1'b0;
          exp_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr_r < PW'(TABLE_DEPTH)) begin
          rd_en       = 1'b1;
          ptr_nxt     = ptr_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = ptr_r[AW-1:0];
        end
        if (chk_vld_r) begin
          if (item_r.kind == KIND_TICK) begin
            if (valid_r[chk_idx_r]) begin
              if (rd_data_r.age > limit) begin
                valid_nxt[chk_idx_r] = 1'b0;
                if (exp_r != COUNT_MAX) begin
                  exp_nxt = exp_r + 1'b1;
                end
                if (f_ok && cnt_r[f_idx] != '0) begin
                  cnt_nxt[f_idx] = cnt_r[f_idx] - 1'b1;
                end
              end else if (rd_data_r.age != AGE_MAX) begin
                wr_en       = 1'b1;
                wr_data.age = rd_data_r.age + 1'b1;
              end
            end
          end else begin
            if (valid_r[chk_idx_r]) begin
              if (!hit_fnd_r && rd_data_r.iface == item_r.iface_index &&
                  rd_data_r.peer_id == item_r.nbr_router_id) begin
                hit_fnd_nxt = 1'b1;
                hit_idx_nxt = chk_idx_r;
              end
            end else if (!free_fnd_r) begin
              free_fnd_nxt = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
          end
          if (chk_idx_r == AW'(TABLE_DEPTH - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        res_nxt   = '0;
        state_nxt = ST_OUT;
        if (item_r.kind == KIND_TICK) begin
          res_nxt.lsu_needed    = (exp_r != '0);
          res_nxt.expired_count = exp_r;
        end else if (ifc_ok) begin
          wr_data = new_entry;
          if (hit_fnd_r) begin
            wr_en             = 1'b1;
            wr_addr           = hit_idx_r;
            res_nxt.refreshed = 1'b1;
          end else if (free_fnd_r) begin
            wr_en                 = 1'b1;
            wr_addr               = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
            cnt_after             = cnt_r[ifc_idx] + 1'b1;
            cnt_nxt[ifc_idx]      = cnt_after;
            res_nxt.added         = 1'b1;
            res_nxt.lsu_needed    = 1'b1;
          end else begin
            res_nxt.full_drop = 1'b1;
          end
          res_nxt.iface_nbr_count = (32'(cnt_after) > 32'(COUNT_MAX)) ?
                                    COUNT_MAX : COUNT_W'(cnt_after);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ptr_r      <= ptr_nxt;
    chk_idx_r  <= chk_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    exp_r      <= exp_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
    hit_fnd_r  <= hit_fnd_nxt;
    free_fnd_r <= free_fnd_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      hello_r     <= HELLO_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_IFACES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      hello_r     <= hello_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/nta_checker.sv =====
module nta_checker
  import nta_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input in_item_t           in_item,
  input logic               out_valid,
  input logic               out_stall,
  input out_item_t          out_item,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [HELLO_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_item.added, out_item.refreshed, out_item.full_drop}))
    else $error("more than one hello outcome");

  a_lsu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.lsu_needed == (out_item.added || out_item.expired_count != '0))
    else $error("lsu_needed inconsistent");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.added || out_item.refreshed) |-> out_item.iface_nbr_count != '0)
    else $error("zero neighbor count after add or refresh");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind neighbor_table_with_aging_core nta_checker u_nta_checker (.*);
